@@ src/xcbc_pkg.sv @@
package xcbc_pkg;

    localparam int ADDR_W      = 6;
    localparam int DATA_W      = 64;
    localparam int REG_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int ROUND_W     = 7;

    localparam logic [31:0] DELTA = 32'h9E37_79B9;
    localparam logic [ROUND_W-1:0] ROUNDS_RESET = 7'd32;

    localparam logic [REG_IDX_W-1:0] REG_KEY0   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_KEY1   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_KEY2   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_KEY3   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_IV     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DECRYPT = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_ROUNDS = 3'd6;

    typedef struct packed {
        logic [3:0][31:0]    key;
        logic [63:0]         iv;
        logic                dec;
        logic [ROUND_W-1:0]  rounds;
    } t_cfg;

    typedef struct packed {
        logic        new_msg;
        logic [31:0] lo;
        logic [31:0] hi;
    } t_item;

    typedef struct packed {
        logic busy;
        logic wr_out;
    } t_bstat;

    function automatic logic [31:0] mix(input logic [31:0] x);
        return ((x << 4) ^ (x >> 5)) + x;
    endfunction

endpackage

@@ src/xcbc_regs.sv @@
module xcbc_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [xcbc_pkg::ADDR_W-1:0] paddr,
    input  logic [xcbc_pkg::DATA_W-1:0] pwdata,
    output logic [xcbc_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output xcbc_pkg::t_cfg              o_cfg
);

    xcbc_pkg::t_cfg r_cfg;
    logic [xcbc_pkg::REG_IDX_W-1:0] s_idx;
    logic s_wr;

    assign s_idx  = paddr[xcbc_pkg::ADDR_W-1:3];
    assign s_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key    <= '0;
            r_cfg.iv     <= '0;
            r_cfg.dec    <= 1'b0;
            r_cfg.rounds <= xcbc_pkg::ROUNDS_RESET;
        end else if (s_wr) begin
            unique case (s_idx)
                xcbc_pkg::REG_KEY0:    r_cfg.key[0] <= pwdata[31:0];
                xcbc_pkg::REG_KEY1:    r_cfg.key[1] <= pwdata[31:0];
                xcbc_pkg::REG_KEY2:    r_cfg.key[2] <= pwdata[31:0];
                xcbc_pkg::REG_KEY3:    r_cfg.key[3] <= pwdata[31:0];
                xcbc_pkg::REG_IV:      r_cfg.iv     <= pwdata;
                xcbc_pkg::REG_DECRYPT: r_cfg.dec    <= pwdata[0];
                xcbc_pkg::REG_ROUNDS:  r_cfg.rounds <= pwdata[xcbc_pkg::ROUND_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (s_idx)
            xcbc_pkg::REG_KEY0:    prdata = {32'd0, r_cfg.key[0]};
            xcbc_pkg::REG_KEY1:    prdata = {32'd0, r_cfg.key[1]};
            xcbc_pkg::REG_KEY2:    prdata = {32'd0, r_cfg.key[2]};
            xcbc_pkg::REG_KEY3:    prdata = {32'd0, r_cfg.key[3]};
            xcbc_pkg::REG_IV:      prdata = r_cfg.iv;
            xcbc_pkg::REG_DECRYPT: prdata = {63'd0, r_cfg.dec};
            xcbc_pkg::REG_ROUNDS:  prdata = {57'd0, r_cfg.rounds};
            default:               prdata = '0;
        endcase
    end

endmodule

@@ src/xcbc_front.sv @@
module xcbc_front #(
    parameter int DEPTH = xcbc_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  xcbc_pkg::t_item i_item,
    output logic            o_full,
    output logic            o_vld,
    output xcbc_pkg::t_item o_item,
    input  logic            i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    xcbc_pkg::t_item r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_cnt;
    logic s_wr, s_rd;

    assign o_full = (r_cnt == CNT_FULL);
    assign o_vld  = (r_cnt != '0);
    assign o_item = r_mem[r_rptr];
    assign s_wr   = i_push && !o_full;
    assign s_rd   = i_pop && o_vld;

    always_ff @(posedge i_clk) begin
        if (s_wr) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (s_wr) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
            end
            if (s_rd) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
            end
            if (s_wr && !s_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (s_rd && !s_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ src/xcbc_back.sv @@
module xcbc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  xcbc_pkg::t_cfg  i_cfg,
    input  logic            i_vld,
    input  xcbc_pkg::t_item i_item,
    output logic            o_take,
    output logic            o_empty,
    input  logic            i_pop,
    output logic [31:0]     o_out_low,
    output logic [31:0]     o_out_high,
    output xcbc_pkg::t_bstat o_stat
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                         r_state;
    logic [xcbc_pkg::ROUND_W-1:0] r_cnt;
    logic [31:0]                  r_v0, r_v1, r_sum;
    logic [63:0]                  r_chain, r_cv, r_held;
    logic                         r_out_vld;
    logic [31:0]                  r_out_lo, r_out_hi;

    logic [63:0] s_cv_sel, s_blk, s_start, s_res;
    logic [31:0] s_sum0;
    logic [31:0] s_e_v0, s_e_v1, s_e_s1;
    logic [31:0] s_d_v0, s_d_v1, s_d_s1;
    logic        s_fin;

    always_comb begin
        s_cv_sel = i_item.new_msg ? i_cfg.iv : r_chain;
        s_blk    = {i_item.hi, i_item.lo};
        s_start  = i_cfg.dec ? s_blk : (s_blk ^ s_cv_sel);
        s_sum0   = i_cfg.dec ? xcbc_pkg::DELTA * 32'(i_cfg.rounds) : 32'd0;

        s_e_v0 = r_v0 + (xcbc_pkg::mix(r_v1) ^ (r_sum + i_cfg.key[r_sum[1:0]]));
        s_e_s1 = r_sum + xcbc_pkg::DELTA;
        s_e_v1 = r_v1 + (xcbc_pkg::mix(s_e_v0) ^ (s_e_s1 + i_cfg.key[s_e_s1[12:11]]));

        s_d_v1 = r_v1 - (xcbc_pkg::mix(r_v0) ^ (r_sum + i_cfg.key[r_sum[12:11]]));
        s_d_s1 = r_sum - xcbc_pkg::DELTA;
        s_d_v0 = r_v0 - (xcbc_pkg::mix(s_d_v1) ^ (s_d_s1 + i_cfg.key[s_d_s1[1:0]]));

        s_res  = i_cfg.dec ? ({r_v1, r_v0} ^ r_cv) : {r_v1, r_v0};
        s_fin  = (r_state == ST_RUN) && (r_cnt == '0) && (!r_out_vld || i_pop);
        o_take = (r_state == ST_IDLE) && i_vld;
    end

    assign o_empty       = !r_out_vld;
    assign o_out_low     = r_out_lo;
    assign o_out_high    = r_out_hi;
    assign o_stat.busy   = (r_state == ST_RUN);
    assign o_stat.wr_out = s_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
            r_chain   <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (o_take) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (s_fin) begin
                        r_state <= ST_IDLE;
                        r_chain <= i_cfg.dec ? r_held : s_res;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            if (s_fin) begin
                r_out_vld <= 1'b1;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_cnt  <= i_cfg.rounds;
            r_sum  <= s_sum0;
            r_v0   <= s_start[31:0];
            r_v1   <= s_start[63:32];
            r_cv   <= s_cv_sel;
            r_held <= s_blk;
        end else if ((r_state == ST_RUN) && (r_cnt != '0)) begin
            r_cnt <= r_cnt - 1'b1;
            if (i_cfg.dec) begin
                r_v0  <= s_d_v0;
                r_v1  <= s_d_v1;
                r_sum <= s_d_s1;
            end else begin
                r_v0  <= s_e_v0;
                r_v1  <= s_e_v1;
                r_sum <= s_e_s1;
            end
        end
        if (s_fin) begin
            r_out_lo <= s_res[31:0];
            r_out_hi <= s_res[63:32];
        end
    end

endmodule

@@ src/xtea_cbc_block_cipher_unit.sv @@
// XTEA in CBC mode over 64-bit blocks. Push one block per beat (low word v0, high word v1);
// set i_new_message to reload the chain value from the IV register before that block.
// Each block runs round_count full XTEA rounds on one shared round unit, one full round per
// clock, so a block occupies the round engine through load, rounds and write-back (the
// round count resets to 32). An input queue keeps accepting blocks until it is full
// while the engine works, and a finished block waits in an output register until popped
// while the next block is already being enciphered; write-back waits for that pop.
module xtea_cbc_block_cipher_unit #(
    parameter int QUEUE_DEPTH = xcbc_pkg::QUEUE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [xcbc_pkg::ADDR_W-1:0] paddr,
    input  logic [xcbc_pkg::DATA_W-1:0] pwdata,
    output logic [xcbc_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        push,
    output logic                        full,
    input  logic                        i_new_message,
    input  logic [31:0]                 i_in_low,
    input  logic [31:0]                 i_in_high,
    output logic                        empty,
    input  logic                        pop,
    output logic [31:0]                 o_out_low,
    output logic [31:0]                 o_out_high
);

    xcbc_pkg::t_cfg   s_cfg;
    xcbc_pkg::t_item  s_in_item, s_q_item;
    xcbc_pkg::t_bstat s_stat;
    logic             s_q_vld, s_q_take;

    assign s_in_item.new_msg = i_new_message;
    assign s_in_item.lo      = i_in_low;
    assign s_in_item.hi      = i_in_high;

    xcbc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (s_cfg)
    );

    xcbc_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (s_in_item),
        .o_full  (full),
        .o_vld   (s_q_vld),
        .o_item  (s_q_item),
        .i_pop   (s_q_take)
    );

    xcbc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (s_cfg),
        .i_vld      (s_q_vld),
        .i_item     (s_q_item),
        .o_take     (s_q_take),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_out_low  (o_out_low),
        .o_out_high (o_out_high),
        .o_stat     (s_stat)
    );

    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_q_take |-> (s_q_vld && !s_stat.busy))
        else $error("engine took a block from an empty queue or while busy");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_stat.wr_out |-> (empty || pop))
        else $error("result register overwritten before pop");

    a_push_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full) |=> s_q_vld)
        else $error("accepted block missing from queue");

    a_take_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_q_take |=> (s_stat.busy && !s_q_take))
        else $error("engine did not start after taking a block");

endmodule

@@ test/tb_xtea_cbc_block_cipher_unit.sv @@
module tb_xtea_cbc_block_cipher_unit;

    localparam logic [xcbc_pkg::REG_IDX_W-1:0] REG_SPARE = 3'd7;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [xcbc_pkg::ADDR_W-1:0]    paddr;
    logic [xcbc_pkg::DATA_W-1:0]    pwdata;
    logic [xcbc_pkg::DATA_W-1:0]    prdata;
    logic                           pready;
    logic                           push;
    logic                           full;
    logic                           i_new_message;
    logic [31:0]                    i_in_low;
    logic [31:0]                    i_in_high;
    logic                           empty;
    logic                           pop;
    logic [31:0]                    o_out_low;
    logic [31:0]                    o_out_high;

    xtea_cbc_block_cipher_unit DUT (.*);

    // cipher state mirrored by the testbench
    logic [31:0]                    key_w [4];
    logic [63:0]                    iv_r;
    logic                           dec_r;
    logic [xcbc_pkg::ROUND_W-1:0]   rounds_r;
    logic [63:0]                    chain_r;

    xcbc_pkg::t_item                pending_q [$];
    logic [63:0]                    out_block_q [$];
    xcbc_pkg::t_item                took;
    logic [63:0]                    blk_want;

    int                   tx_idle_pct;
    int                   rx_idle_pct;
    bit                   tx_hold;
    int                   rx_stall_left;
    int                   errors;
    int                   blocks_in;
    int                   blocks_out;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [31:0] round_mix(input logic [31:0] x);
        return ((x << 4) ^ (x >> 5)) + x;
    endfunction

    function automatic logic [63:0] xtea_cbc_block(input xcbc_pkg::t_item blk);
        logic [31:0] v0;
        logic [31:0] v1;
        logic [31:0] s;
        logic [63:0] held;
        if (blk.new_msg) chain_r = iv_r;
        v0 = blk.lo;
        v1 = blk.hi;
        if (dec_r) begin
            held = {v1, v0};
            s = xcbc_pkg::DELTA * 32'(rounds_r);
            for (int n = 0; n < int'(rounds_r); n++) begin
                v1 -= round_mix(v0) ^ (s + key_w[s[12:11]]);
                s -= xcbc_pkg::DELTA;
                v0 -= round_mix(v1) ^ (s + key_w[s[1:0]]);
            end
            v0 ^= chain_r[31:0];
            v1 ^= chain_r[63:32];
            chain_r = held;
        end else begin
            v0 ^= chain_r[31:0];
            v1 ^= chain_r[63:32];
            s = 32'd0;
            for (int n = 0; n < int'(rounds_r); n++) begin
                v0 += round_mix(v1) ^ (s + key_w[s[1:0]]);
                s += xcbc_pkg::DELTA;
                v1 += round_mix(v0) ^ (s + key_w[s[12:11]]);
            end
            chain_r = {v1, v0};
        end
        return {v1, v0};
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // sender: offer the oldest pending block, predict on each accepted beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                took.new_msg = i_new_message;
                took.lo = i_in_low;
                took.hi = i_in_high;
                out_block_q.push_back(xtea_cbc_block(took));
                void'(pending_q.pop_front());
                blocks_in++;
            end
            if (pending_q.size() > 0 && !tx_hold && $urandom_range(99) >= tx_idle_pct) begin
                push <= 1'b1;
                i_new_message <= pending_q[0].new_msg;
                i_in_low <= pending_q[0].lo;
                i_in_high <= pending_q[0].hi;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // receiver: check each popped beat against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (out_block_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected block %08h_%08h",
                                              o_out_high, o_out_low));
                end else begin
                    blk_want = out_block_q.pop_front();
                    if (o_out_low !== blk_want[31:0])
                        report_mismatch($sformatf("block %0d out_low %08h, expected %08h",
                                                  blocks_out, o_out_low, blk_want[31:0]));
                    if (o_out_high !== blk_want[63:32])
                        report_mismatch($sformatf("block %0d out_high %08h, expected %08h",
                                                  blocks_out, o_out_high, blk_want[63:32]));
                end
                blocks_out++;
            end
            pop <= (rx_stall_left == 0) && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (rx_stall_left > 0) rx_stall_left <= rx_stall_left - 1;
    end

    task automatic cfg_write(input logic [xcbc_pkg::REG_IDX_W-1:0] idx,
                             input logic [63:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            xcbc_pkg::REG_KEY0, xcbc_pkg::REG_KEY1,
            xcbc_pkg::REG_KEY2, xcbc_pkg::REG_KEY3: key_w[idx[1:0]] = val[31:0];
            xcbc_pkg::REG_IV:      iv_r = val;
            xcbc_pkg::REG_DECRYPT: dec_r = val[0];
            xcbc_pkg::REG_ROUNDS:  rounds_r = val[xcbc_pkg::ROUND_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_keys(input logic [63:0] k0, k1, k2, k3);
        cfg_write(xcbc_pkg::REG_KEY0, k0);
        cfg_write(xcbc_pkg::REG_KEY1, k1);
        cfg_write(xcbc_pkg::REG_KEY2, k2);
        cfg_write(xcbc_pkg::REG_KEY3, k3);
    endtask

    task automatic queue_block(input bit nm, input logic [31:0] lo, input logic [31:0] hi);
        xcbc_pkg::t_item blk;
        blk.new_msg = nm;
        blk.lo = lo;
        blk.hi = hi;
        pending_q.push_back(blk);
    endtask

    function automatic logic [31:0] any_word();
        case ($urandom_range(15))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // mostly whole messages led by a start flag; some continue the old chain,
    // some carry stray start flags
    task automatic queue_messages(input int n);
        int left;
        int len;
        int kind;
        left = n;
        while (left > 0) begin
            len = $urandom_range(1, 12);
            if (len > left) len = left;
            kind = $urandom_range(19);
            for (int k = 0; k < len; k++)
                queue_block(kind == 0 ? 1'b0 : (k == 0 || (kind < 3 && $urandom_range(3) == 0)),
                            any_word(), any_word());
            left -= len;
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_q.size() != 0 || out_block_q.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        int n_items;
        logic [63:0] rounds_val;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        push = 1'b0;
        i_new_message = 1'b0;
        i_in_low = '0;
        i_in_high = '0;
        pop = 1'b0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        tx_hold = 1'b0;
        rx_stall_left = 0;
        errors = 0;
        blocks_in = 0;
        blocks_out = 0;
        for (int k = 0; k < 4; k++) key_w[k] = '0;
        iv_r = '0;
        dec_r = 1'b0;
        rounds_r = xcbc_pkg::ROUNDS_RESET;
        chain_r = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, chain starts at zero without a start flag
        @(negedge i_clk);
        queue_block(1'b0, 32'h0000_0000, 32'h0000_0000);
        queue_block(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_block(1'b1, 32'h0123_4567, 32'h89AB_CDEF);
        wait_drained();

        set_keys('1, '1, '1, '1);
        cfg_write(xcbc_pkg::REG_IV, '1);
        cfg_write(xcbc_pkg::REG_ROUNDS, 64'hDEAD_BEEF_0000_0F81);
        @(negedge i_clk);
        queue_block(1'b1, 32'h0000_0000, 32'h0000_0000);
        queue_block(1'b0, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_block(1'b0, 32'h0000_0000, 32'hFFFF_FFFF);
        wait_drained();

        // a new IV only counts from the next start flag
        cfg_write(xcbc_pkg::REG_IV, 64'h0F1E_2D3C_4B5A_6978);
        @(negedge i_clk);
        queue_block(1'b0, $urandom, $urandom);
        queue_block(1'b1, $urandom, $urandom);
        wait_drained();

        // zero rounds leaves the chaining XOR only
        cfg_write(xcbc_pkg::REG_ROUNDS, 64'd0);
        @(negedge i_clk);
        queue_block(1'b1, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_block(1'b0, $urandom, $urandom);
        wait_drained();
        cfg_write(xcbc_pkg::REG_DECRYPT, '1);
        @(negedge i_clk);
        queue_block(1'b1, $urandom, $urandom);
        queue_block(1'b0, $urandom, $urandom);
        wait_drained();

        set_keys({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom});
        cfg_write(xcbc_pkg::REG_ROUNDS, 64'h7F);
        @(negedge i_clk);
        queue_block(1'b1, $urandom, $urandom);
        queue_block(1'b0, $urandom, $urandom);
        wait_drained();
        cfg_write(xcbc_pkg::REG_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFE);
        cfg_write(xcbc_pkg::REG_ROUNDS, 64'd64);
        @(negedge i_clk);
        queue_block(1'b1, $urandom, $urandom);
        queue_block(1'b0, $urandom, $urandom);
        wait_drained();

        // write to an unused register index must change nothing
        cfg_write(REG_SPARE, {$urandom, $urandom});
        @(negedge i_clk);
        queue_block(1'b0, $urandom, $urandom);
        wait_drained();

        for (int ph = 0; ph < 12; ph++) begin
            set_keys({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom});
            cfg_write(xcbc_pkg::REG_IV, {$urandom, $urandom});
            cfg_write(xcbc_pkg::REG_DECRYPT, (ph % 3 == 1) ? 64'd1 : 64'd0);
            case (ph)
                6:       rounds_val = 64'd32;
                7:       rounds_val = 64'd127;
                8:       rounds_val = 64'd0;
                9:       rounds_val = 64'd64;
                default: rounds_val = 64'($urandom_range(1, 10));
            endcase
            cfg_write(xcbc_pkg::REG_ROUNDS, rounds_val);
            n_items = (ph == 7) ? 40 : (ph == 9) ? 60 : 140;
            @(negedge i_clk);
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
                1: begin tx_idle_pct = 76; rx_idle_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_idle_pct = 76; end
                default: begin tx_idle_pct = 22; rx_idle_pct = 22; end
            endcase
            // hold the receiver off long enough for the block to fill and stall
            if (ph == 4) rx_stall_left = 600;
            queue_messages(n_items);
            if (ph == 5) begin
                while (pending_q.size() > n_items / 2) @(negedge i_clk);
                tx_hold = 1'b1;
                while (out_block_q.size() != 0) @(negedge i_clk);
                tx_hold = 1'b0;
            end
            wait_drained();
        end

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (140) @(posedge i_clk);
        $display("%0d blocks sent and %0d checked over 12 random settings",
                 blocks_in, blocks_out);
        $display("rounds 0 to 127, both chaining directions, idling, stalls and a full input queue");
        if (errors == 0) begin
            $display("xtea_cbc_block_cipher_unit regression: pass");
        end else begin
            $display("xtea_cbc_block_cipher_unit regression: fail");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("xtea_cbc_block_cipher_unit regression: fail");
        $finish;
    end

endmodule
